/* rtl/modexp_pkg.sv */
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared constants for the modular exponentiation block: default operand
// width and configuration register indexes.
// ----------------------------------------------------------------------------
package modexp_pkg;

    localparam int DEFAULT_OPERAND_WIDTH = 32;
    localparam int CFG_INDEX_WIDTH       = 1;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_EXPONENT = 1'b0,
        CFG_MODULUS  = 1'b1
    } cfg_index_t;

endpackage

/* rtl/modexp_base_if.sv */
// ----------------------------------------------------------------------------
// modexp_base_if
// Input channel: one base value per beat.
// ----------------------------------------------------------------------------
interface modexp_base_if
    import modexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = DEFAULT_OPERAND_WIDTH
);
    logic                     valid;
    logic                     ready;
    logic [OPERAND_WIDTH-1:0] base_value;

    modport source (output valid, output base_value, input ready);
    modport sink   (input valid, input base_value, output ready);
endinterface

/* rtl/modexp_result_if.sv */
// ----------------------------------------------------------------------------
// modexp_result_if
// Output channel: one power result per beat.
// ----------------------------------------------------------------------------
interface modexp_result_if
    import modexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = DEFAULT_OPERAND_WIDTH
);
    logic                     valid;
    logic                     ready;
    logic [OPERAND_WIDTH-1:0] power_result;

    modport source (output valid, output power_result, input ready);
    modport sink   (input valid, input power_result, output ready);
endinterface

/* rtl/modexp_cfg_if.sv */
// ----------------------------------------------------------------------------
// modexp_cfg_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface modexp_cfg_if
    import modexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = DEFAULT_OPERAND_WIDTH
);
    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [OPERAND_WIDTH-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/modexp_mulmod.sv */
// ----------------------------------------------------------------------------
// modexp_mulmod
// Bit-serial interleaved modular multiplier: product = a * b mod m, one
// multiplier bit per cycle, MSB first. Requires a < m; a and m held stable.
// ----------------------------------------------------------------------------
module modexp_mulmod
    import modexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = DEFAULT_OPERAND_WIDTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [OPERAND_WIDTH-1:0] a,
    input  logic [OPERAND_WIDTH-1:0] b,
    input  logic [OPERAND_WIDTH-1:0] m,
    output logic                     done,
    output logic [OPERAND_WIDTH-1:0] product
);

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  acc_reg;
    logic [W-1:0]  mplier_reg;
    logic [CW-1:0] count_reg;
    logic          run_reg;
    logic          done_reg;

    logic [W:0]    dbl;
    logic [W:0]    dbl_red;
    logic [W:0]    sum;
    logic [W:0]    sum_red;
    logic [W-1:0]  step;

    always_comb
    begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m}) ? (dbl - {1'b0, m}) : dbl;
        sum     = {1'b0, dbl_red[W-1:0]} + {1'b0, a};
        sum_red = (sum >= {1'b0, m}) ? (sum - {1'b0, m}) : sum;
        step    = mplier_reg[W-1] ? sum_red[W-1:0] : dbl_red[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg   <= 1'b1;
                count_reg <= CW'(W);
            end
            else if (run_reg)
            begin
                count_reg <= count_reg - CW'(1);
                if (count_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mplier_reg <= b;
        end
        else if (run_reg)
        begin
            acc_reg    <= step;
            mplier_reg <= {mplier_reg[W-2:0], 1'b0};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

/* rtl/modular_exponentiation.sv */
// ----------------------------------------------------------------------------
// modular_exponentiation
// Raises each base to the key exponent modulo the key modulus by binary
// square-and-multiply over one shared bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// Each base beat yields one result beat, base^exponent mod modulus. The
// exponent (index 0) and modulus (index 1) are to be written on the
// configuration channel while the block is idle; the block itself does
// not enforce this. Every operation runs on one bit-serial modular
// multiplier: one pass to reduce the base, one per set exponent bit and one
// per squaring up to the top set bit. A zero exponent gives 1 mod modulus, a
// zero modulus gives 0. The block takes one base at a time; a new base is
// accepted while the previous result still waits.
// ----------------------------------------------------------------------------
module modular_exponentiation
    import modexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = DEFAULT_OPERAND_WIDTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    modexp_base_if.sink      base,
    modexp_result_if.source  result,
    modexp_cfg_if.sink       cfg
);

    localparam int W = OPERAND_WIDTH;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MULT,
        ST_SQUARE,
        ST_DONE
    } state_t;

    state_t       state_reg, state_next;
    logic [W-1:0] exp_reg;
    logic [W-1:0] mod_reg;
    logic [W-1:0] e_reg, e_next;
    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] power_reg, power_next;
    logic         start_reg, start_next;
    logic         out_valid_reg, out_valid_next;
    logic [W-1:0] out_data_reg, out_data_next;

    logic [W-1:0] one_mod;
    logic [W-1:0] mul_a;
    logic         mul_done;
    logic [W-1:0] mul_product;
    logic [W-1:0] e_half;

    assign one_mod = (mod_reg == W'(1)) ? '0 : W'(1);
    assign e_half  = e_reg >> 1;

    always_comb
    begin
        case (state_reg)
            ST_REDUCE: mul_a = one_mod;
            ST_MULT:   mul_a = acc_reg;
            default:   mul_a = power_reg;
        endcase
    end

    modexp_mulmod #(
        .OPERAND_WIDTH (W)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .a       (mul_a),
        .b       (power_reg),
        .m       (mod_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    assign base.ready  = (state_reg == ST_IDLE);
    assign cfg.ready   = 1'b1;
    assign result.valid        = out_valid_reg;
    assign result.power_result = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg <= W'(1);
            mod_reg <= W'(2);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_EXPONENT: exp_reg <= cfg.data;
                CFG_MODULUS:  mod_reg <= cfg.data;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        e_next         = e_reg;
        acc_next       = acc_reg;
        power_next     = power_reg;
        start_next     = 1'b0;
        out_valid_next = out_valid_reg && !result.ready;
        out_data_next  = out_data_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (base.valid)
                begin
                    power_next = base.base_value;
                    e_next     = exp_reg;
                    if (mod_reg == '0)
                    begin
                        acc_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        acc_next   = one_mod;
                        start_next = 1'b1;
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (mul_done)
                begin
                    power_next = mul_product;
                    if (e_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        start_next = 1'b1;
                        state_next = e_reg[0] ? ST_MULT : ST_SQUARE;
                    end
                end
            end
            ST_MULT:
            begin
                if (mul_done)
                begin
                    acc_next = mul_product;
                    if (e_half == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        start_next = 1'b1;
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_SQUARE:
            begin
                if (mul_done)
                begin
                    power_next = mul_product;
                    e_next     = e_half;
                    start_next = 1'b1;
                    state_next = e_half[0] ? ST_MULT : ST_SQUARE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg        <= e_next;
        acc_reg      <= acc_next;
        power_reg    <= power_next;
        out_data_reg <= out_data_next;
    end

endmodule
